// File: sv/npc_pkg.sv
package npc_pkg;

    // Field widths
    localparam int COORD_BITS  = 24;
    localparam int DIST_BITS   = 23;
    localparam int INDEX_BITS  = 10;
    localparam int DSQ_BITS    = 46;
    localparam int MAX_TARGETS = 1024;

    // Width of the squared distance sum before it is checked against the gate
    localparam int SUM_BITS = 2 * COORD_BITS + 1;

    // Reset value of the gating distance register
    localparam logic [DIST_BITS-1:0] MAX_DISTANCE_RESET = DIST_BITS'(4096);

    // Item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } item_t;

    typedef struct packed {
        logic                         matched;
        logic signed [COORD_BITS-1:0] source_x;
        logic signed [COORD_BITS-1:0] source_y;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic [INDEX_BITS-1:0]        target_index;
        logic [DSQ_BITS-1:0]          distance_sq;
        logic                         overflowed;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic load_query;
        logic issue;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_end;
        logic pipe_busy;
    } ctrl_status_t;

endpackage

// File: sv/npc_controller.sv
module npc_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    output logic                  busy,
    output npc_pkg::ctrl_cmd_t    cmd,
    input  npc_pkg::ctrl_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.clear      = (kind == npc_pkg::KIND_CLEAR);
                    cmd.append     = (kind == npc_pkg::KIND_APPEND);
                    cmd.load_query = (kind == npc_pkg::KIND_QUERY);
                    if (kind == npc_pkg::KIND_QUERY)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait until the last compare has updated the best match
                if (!status.pipe_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: sv/npc_datapath.sv
module npc_datapath #(
    parameter int MAX_TARGETS = npc_pkg::MAX_TARGETS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  npc_pkg::item_t                      item,
    input  logic                                cfg_we,
    input  logic [npc_pkg::DIST_BITS-1:0]       cfg_data,
    input  npc_pkg::ctrl_cmd_t                  cmd,
    output npc_pkg::ctrl_status_t               status,
    output logic                                result_valid,
    output npc_pkg::result_t                    result
);

    localparam int CB     = npc_pkg::COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
    localparam int ADDR_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int DSQ_W  = npc_pkg::DSQ_BITS;
    localparam int SUM_W  = npc_pkg::SUM_BITS;

    // Target table
    logic [2*CB-1:0] mem [MAX_TARGETS];

    logic [CNT_W-1:0]                count_reg;
    logic                            ovf_reg;
    logic [npc_pkg::DIST_BITS-1:0]   maxd_reg;
    logic signed [CB-1:0]            src_x_reg;
    logic signed [CB-1:0]            src_y_reg;
    logic [CNT_W-1:0]                addr_reg;

    // Pipeline stage 1: table read
    logic                            v1_reg;
    logic [ADDR_W-1:0]               idx1_reg;
    logic [2*CB-1:0]                 rd_reg;
    // Stage 2: absolute differences
    logic                            v2_reg;
    logic [ADDR_W-1:0]               idx2_reg;
    logic signed [CB-1:0]            tx2_reg;
    logic signed [CB-1:0]            ty2_reg;
    logic [CB-1:0]                   dx2_reg;
    logic [CB-1:0]                   dy2_reg;
    // Stage 3: squares
    logic                            v3_reg;
    logic [ADDR_W-1:0]               idx3_reg;
    logic signed [CB-1:0]            tx3_reg;
    logic signed [CB-1:0]            ty3_reg;
    logic [2*CB-1:0]                 sqx3_reg;
    logic [2*CB-1:0]                 sqy3_reg;
    // Best match so far
    logic                            found_reg;
    logic [DSQ_W-1:0]                best_reg;
    logic [ADDR_W-1:0]               best_idx_reg;
    logic signed [CB-1:0]            best_x_reg;
    logic signed [CB-1:0]            best_y_reg;
    // Result register
    logic                            res_valid_reg;
    npc_pkg::result_t                res_reg;

    logic                            table_full;
    logic [DSQ_W-1:0]                gate_calc;
    logic signed [CB-1:0]            rd_x;
    logic signed [CB-1:0]            rd_y;
    logic signed [CB:0]              diff_x;
    logic signed [CB:0]              diff_y;
    logic [CB:0]                     mag_x;
    logic [CB:0]                     mag_y;
    logic [SUM_W-1:0]                sum3;
    logic                            better;

    assign table_full = (count_reg == CNT_W'(MAX_TARGETS));
    assign gate_calc  = maxd_reg * maxd_reg;

    // Table write on append
    always_ff @(posedge clk)
    begin
        if (cmd.append && !table_full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {item.point_x, item.point_y};
        end
    end

    // Table read, registered
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_reg   <= mem[addr_reg[ADDR_W-1:0]];
            idx1_reg <= addr_reg[ADDR_W-1:0];
        end
    end

    // Table fill state, gate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            maxd_reg  <= npc_pkg::MAX_DISTANCE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                maxd_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (cmd.append)
            begin
                if (table_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // Scan address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.load_query)
        begin
            addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    assign status.scan_end  = (addr_reg == count_reg);
    assign status.pipe_busy = v1_reg | v2_reg | v3_reg;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 2: signed differences and their magnitudes
    assign rd_x   = rd_reg[2*CB-1:CB];
    assign rd_y   = rd_reg[CB-1:0];
    assign diff_x = {src_x_reg[CB-1], src_x_reg} - {rd_x[CB-1], rd_x};
    assign diff_y = {src_y_reg[CB-1], src_y_reg} - {rd_y[CB-1], rd_y};
    assign mag_x  = diff_x[CB] ? (~diff_x + 1'b1) : diff_x;
    assign mag_y  = diff_y[CB] ? (~diff_y + 1'b1) : diff_y;

    always_ff @(posedge clk)
    begin
        idx2_reg <= idx1_reg;
        tx2_reg  <= rd_x;
        ty2_reg  <= rd_y;
        dx2_reg  <= mag_x[CB-1:0];
        dy2_reg  <= mag_y[CB-1:0];
    end

    // Stage 3: one multiplier per axis
    always_ff @(posedge clk)
    begin
        idx3_reg <= idx2_reg;
        tx3_reg  <= tx2_reg;
        ty3_reg  <= ty2_reg;
        sqx3_reg <= dx2_reg * dx2_reg;
        sqy3_reg <= dy2_reg * dy2_reg;
    end

    // Stage 4: sum and strict compare, earliest index wins ties
    assign sum3   = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
    assign better = v3_reg && (sum3 < SUM_W'(best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load_query)
        begin
            found_reg <= 1'b0;
        end
        else if (better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            best_reg  <= gate_calc;
            src_x_reg <= item.point_x;
            src_y_reg <= item.point_y;
        end
        else if (better)
        begin
            best_reg     <= sum3[DSQ_W-1:0];
            best_idx_reg <= idx3_reg;
            best_x_reg   <= tx3_reg;
            best_y_reg   <= ty3_reg;
        end
    end

    // Result register, one cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg.matched    <= found_reg;
            res_reg.source_x   <= src_x_reg;
            res_reg.source_y   <= src_y_reg;
            res_reg.overflowed <= ovf_reg;
            if (found_reg)
            begin
                res_reg.target_x     <= best_x_reg;
                res_reg.target_y     <= best_y_reg;
                res_reg.target_index <= npc_pkg::INDEX_BITS'(best_idx_reg);
                res_reg.distance_sq  <= best_reg;
            end
            else
            begin
                res_reg.target_x     <= '0;
                res_reg.target_y     <= '0;
                res_reg.target_index <= '0;
                res_reg.distance_sq  <= '0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: sv/nearest_point_correspondence.sv
// Nearest target point search over a table of 2D targets.
// Command channel: item (kind, point_x, point_y) is taken at a clock edge with
// start high and busy low. A clear or append transaction completes in that
// edge and leaves busy low, so such transactions can be issued every cycle.
// Kind 3 is taken and ignored.
// A query raises busy and scans every stored target in index order with one
// distance unit (table read, differences, squares, sum and compare stages).
// The result strobe result_valid rises at the edge at which busy drops, so the
// next transaction may start while the result is shown. No new transaction is
// taken while a query is running.
// The receiver cannot stall: each result is valid for exactly one cycle.
// cfg_we/cfg_data write the gating distance. The user must write it only while
// no query is running; the block itself does not enforce this.
// Reset empties the table, clears the overflow flag and sets the gate to 4096;
// table contents are not cleared and need no clearing pass.
module nearest_point_correspondence #(
    parameter int MAX_TARGETS = npc_pkg::MAX_TARGETS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  npc_pkg::item_t                item,
    input  logic                          cfg_we,
    input  logic [npc_pkg::DIST_BITS-1:0] cfg_data,
    output logic                          result_valid,
    output npc_pkg::result_t              result
);

    npc_pkg::ctrl_cmd_t    cmd;
    npc_pkg::ctrl_status_t status;

    npc_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    npc_datapath #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    // A result follows only a running query
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a running query");

    // One strobe per query
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // Unmatched results carry zero target fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.matched) |->
            (result.distance_sq == '0 && result.target_index == '0 &&
             result.target_x == '0 && result.target_y == '0))
        else $error("unmatched result with nonzero target fields");

endmodule

// File: bench/nearest_point_correspondence_tb.sv
module nearest_point_correspondence_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Kind code the block takes and ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Cycles allowed for the whole run
    localparam int CYCLE_LIMIT = 10_000_000;
    // Cycles let pass after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 8;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    npc_pkg::item_t                item = '0;
    logic                          cfg_we = 1'b0;
    logic [npc_pkg::DIST_BITS-1:0] cfg_data = npc_pkg::MAX_DISTANCE_RESET;
    logic                          result_valid;
    npc_pkg::result_t              result;

    // Mirror of the target table and the gate
    logic signed [npc_pkg::COORD_BITS-1:0] table_x [npc_pkg::MAX_TARGETS];
    logic signed [npc_pkg::COORD_BITS-1:0] table_y [npc_pkg::MAX_TARGETS];
    int                                    table_count = 0;
    logic                                  table_overflow = 1'b0;
    logic [npc_pkg::DIST_BITS-1:0]         gate_dist = npc_pkg::MAX_DISTANCE_RESET;

    // Search results still due from the block, oldest first
    npc_pkg::result_t pending_searches [$];

    int               mismatch_count = 0;
    int               cycle_count = 0;
    bit               no_idle = 1'b0;
    npc_pkg::result_t want;

    nearest_point_correspondence uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Brute force scan of the mirrored table for one query
    function automatic npc_pkg::result_t nearest_target(input npc_pkg::item_t q);
        npc_pkg::result_t r;
        longint           px, py, dx, dy, d, best, gate;
        int               best_i;
        bit               found;
        px = $signed(q.point_x);
        py = $signed(q.point_y);
        gate = longint'(gate_dist) * longint'(gate_dist);
        best = gate;
        best_i = 0;
        found = 1'b0;
        for (int i = 0; i < table_count; i++)
        begin
            dx = px - longint'($signed(table_x[i]));
            dy = py - longint'($signed(table_y[i]));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            d = dx * dx + dy * dy;
            // strictly below the best so far: earliest index wins ties
            if (d < best)
            begin
                best = d;
                best_i = i;
                found = 1'b1;
            end
        end
        r.matched      = found;
        r.source_x     = q.point_x;
        r.source_y     = q.point_y;
        r.target_x     = found ? table_x[best_i] : '0;
        r.target_y     = found ? table_y[best_i] : '0;
        r.target_index = found ? npc_pkg::INDEX_BITS'(best_i) : '0;
        r.distance_sq  = found ? npc_pkg::DSQ_BITS'(best) : '0;
        r.overflowed   = table_overflow;
        return r;
    endfunction

    // Update the mirror for one accepted transaction
    task automatic track_item(input npc_pkg::item_t it);
        case (it.kind)
            npc_pkg::KIND_CLEAR:
            begin
                table_count = 0;
                table_overflow = 1'b0;
            end
            npc_pkg::KIND_APPEND:
            begin
                if (table_count < npc_pkg::MAX_TARGETS)
                begin
                    table_x[table_count] = it.point_x;
                    table_y[table_count] = it.point_y;
                    table_count++;
                end
                else
                begin
                    table_overflow = 1'b1;
                end
            end
            npc_pkg::KIND_QUERY:
                pending_searches = {pending_searches, nearest_target(it)};
            default: ;
        endcase
    endtask

    function automatic npc_pkg::item_t make_item(input logic [1:0] kind, input int x,
                                                 input int y);
        npc_pkg::item_t it;
        it.kind    = kind;
        it.point_x = npc_pkg::COORD_BITS'(x);
        it.point_y = npc_pkg::COORD_BITS'(y);
        return it;
    endfunction

    // Random coordinate within +-spread of a center; wraps at the range ends
    function automatic int near(input logic signed [npc_pkg::COORD_BITS-1:0] center,
                                input int spread);
        longint v;
        v = longint'(center) + longint'($urandom_range(2 * spread)) - spread;
        return int'(v);
    endfunction

    // Offer one transaction, idling single cycles at random first
    task automatic send_item(input npc_pkg::item_t it);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 16)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        track_item(it);
    endtask

    // Stop sending until every outstanding search has reported
    task automatic drain_searches();
        start <= 1'b0;
        while (pending_searches.size() != 0) @(posedge clk);
    endtask

    // Gate register write, only with the block idle
    task automatic write_gate(input logic [npc_pkg::DIST_BITS-1:0] value);
        drain_searches();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        gate_dist = value;
    endtask

    task automatic show_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    endtask

    // Result checker: every strobe is one transaction
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_searches.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected result, expected none, actual %0h", $time, result);
            end
            else
            begin
                want = pending_searches.pop_front();
                if (want.matched !== result.matched)
                    show_mismatch("matched", want.matched, result.matched);
                if (want.source_x !== result.source_x)
                    show_mismatch("source_x", want.source_x, result.source_x);
                if (want.source_y !== result.source_y)
                    show_mismatch("source_y", want.source_y, result.source_y);
                if (want.target_x !== result.target_x)
                    show_mismatch("target_x", want.target_x, result.target_x);
                if (want.target_y !== result.target_y)
                    show_mismatch("target_y", want.target_y, result.target_y);
                if (want.target_index !== result.target_index)
                    show_mismatch("target_index", want.target_index, result.target_index);
                if (want.distance_sq !== result.distance_sq)
                    show_mismatch("distance_sq", want.distance_sq, result.distance_sq);
                if (want.overflowed !== result.overflowed)
                    show_mismatch("overflowed", want.overflowed, result.overflowed);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nearest_point_correspondence_tb NOT OK");
            $finish;
        end
    end

    // Reset gate, empty table, ties, strict gate boundary, ignored kind
    task automatic test_gate_boundary();
        send_item(make_item(npc_pkg::KIND_QUERY, 0, 0));
        send_item(make_item(npc_pkg::KIND_CLEAR, 0, 0));
        send_item(make_item(npc_pkg::KIND_APPEND, 0, 0));
        send_item(make_item(npc_pkg::KIND_APPEND, 4096, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, 4096, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, 2048, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, -4096, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, -4095, 0));
        send_item(make_item(KIND_UNUSED, -8388608, 8388607));
        send_item(make_item(npc_pkg::KIND_APPEND, 0, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, 0, 0));
    endtask

    // Coordinate extremes with the widest gate, then zero and unit gates
    task automatic test_extremes();
        write_gate({npc_pkg::DIST_BITS{1'b1}});
        send_item(make_item(npc_pkg::KIND_CLEAR, 0, 0));
        send_item(make_item(npc_pkg::KIND_APPEND, -8388608, -8388608));
        send_item(make_item(npc_pkg::KIND_APPEND, 8388607, 8388607));
        send_item(make_item(npc_pkg::KIND_QUERY, 8388607, -8388608));
        send_item(make_item(npc_pkg::KIND_QUERY, 0, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, 4000000, 4000000));
        send_item(make_item(npc_pkg::KIND_QUERY, -8388508, -8388608));
        write_gate('0);
        send_item(make_item(npc_pkg::KIND_QUERY, 8388607, 8388607));
        write_gate(npc_pkg::DIST_BITS'(1));
        send_item(make_item(npc_pkg::KIND_QUERY, 8388607, 8388607));
        send_item(make_item(npc_pkg::KIND_QUERY, 8388606, 8388607));
    endtask

    // Fill the table, drop appends past the end, then clear the sticky flag
    task automatic test_full_table();
        write_gate(npc_pkg::DIST_BITS'(3000));
        send_item(make_item(npc_pkg::KIND_CLEAR, 0, 0));
        for (int i = 0; i < npc_pkg::MAX_TARGETS; i++)
            send_item(make_item(npc_pkg::KIND_APPEND, near('0, 20000), near('0, 20000)));
        repeat (3)
            send_item(make_item(npc_pkg::KIND_QUERY, near('0, 20000), near('0, 20000)));
        repeat (2)
            send_item(make_item(npc_pkg::KIND_APPEND, near('0, 20000), near('0, 20000)));
        repeat (2)
            send_item(make_item(npc_pkg::KIND_QUERY, near('0, 20000), near('0, 20000)));
        send_item(make_item(npc_pkg::KIND_CLEAR, 0, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, 5, 5));
        send_item(make_item(npc_pkg::KIND_APPEND, 0, 0));
        send_item(make_item(npc_pkg::KIND_QUERY, 5, 5));
    endtask

    // Mostly clear / append cluster / query near cluster, with random noise
    task automatic random_phase(input logic [npc_pkg::DIST_BITS-1:0] gate,
                                input int item_goal, input int spread, input bit steady,
                                input bit pause_once);
        int                                    sent;
        int                                    n;
        bit                                    paused;
        npc_pkg::item_t                        it;
        logic signed [npc_pkg::COORD_BITS-1:0] cx, cy;
        write_gate(gate);
        no_idle = steady;
        sent = 0;
        paused = 1'b0;
        while (sent < item_goal)
        begin
            if ($urandom_range(99) < 15)
            begin
                it.kind    = 2'($urandom);
                it.point_x = npc_pkg::COORD_BITS'($urandom);
                it.point_y = npc_pkg::COORD_BITS'($urandom);
                send_item(it);
                if (it.kind != KIND_UNUSED) sent++;
            end
            else
            begin
                cx = npc_pkg::COORD_BITS'($urandom);
                cy = npc_pkg::COORD_BITS'($urandom);
                if ($urandom_range(4) != 0 || table_count > 200)
                begin
                    send_item(make_item(npc_pkg::KIND_CLEAR, 0, 0));
                    sent++;
                end
                n = $urandom_range(1, ($urandom_range(9) == 0) ? 48 : 12);
                repeat (n)
                    send_item(make_item(npc_pkg::KIND_APPEND, near(cx, spread),
                                        near(cy, spread)));
                sent += n;
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(make_item(npc_pkg::KIND_QUERY, near(cx, spread),
                                        near(cy, spread)));
                sent += n;
                if (pause_once && !paused && sent > item_goal / 2)
                begin
                    drain_searches();
                    paused = 1'b1;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int g;
        random_phase(npc_pkg::MAX_DISTANCE_RESET, 97, 6000, 1'b0, 1'b1);
        random_phase('0, 97, 3, 1'b0, 1'b0);
        random_phase(npc_pkg::DIST_BITS'(1), 97, 2, 1'b1, 1'b0);
        random_phase({npc_pkg::DIST_BITS{1'b1}}, 97, 4000000, 1'b0, 1'b0);
        g = $urandom_range(2, 500);
        random_phase(npc_pkg::DIST_BITS'(g), 97, g + g / 2, 1'b0, 1'b0);
        g = $urandom_range(100000, 8388607);
        random_phase(npc_pkg::DIST_BITS'(g), 97, g, 1'b0, 1'b0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_gate_boundary();
        test_extremes();
        test_full_table();
        test_random();
        drain_searches();
        repeat (SETTLE_CYCLES * 3) @(posedge clk);
        if (mismatch_count == 0)
            $display("nearest_point_correspondence_tb OK");
        else
            $display("nearest_point_correspondence_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
sv/npc_pkg.sv
sv/npc_controller.sv
sv/npc_datapath.sv
sv/nearest_point_correspondence.sv
bench/nearest_point_correspondence_tb.sv
